>>> hdl/fpd_pkg.sv
package fpd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TS_W       = 32;
   localparam int CFG_W      = 16;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK_SPACING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LOW     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_HIGH    = 2'd3;

   localparam logic signed [CFG_W-1:0] RST_PEAK_THRESHOLD   = 16'sd0;
   localparam logic [CFG_W-1:0]        RST_MIN_PEAK_SPACING = 16'd300;
   localparam logic [CFG_W-1:0]        RST_INTERVAL_LOW     = 16'd300;
   localparam logic [CFG_W-1:0]        RST_INTERVAL_HIGH    = 16'd2000;

   typedef struct packed {
      logic signed [CFG_W-1:0] peak_threshold;
      logic [CFG_W-1:0]        min_peak_spacing_ms;
      logic [CFG_W-1:0]        interval_low_ms;
      logic [CFG_W-1:0]        interval_high_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       peak;
      logic [INTERVAL_W-1:0]      interval_ms;
      logic                       interval_valid;
   } result_type;

endpackage

>>> hdl/fpd_tap_cell.sv
module fpd_tap_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic signed [fpd_pkg::SAMPLE_W-1:0] tap_in,
   output logic signed [fpd_pkg::SAMPLE_W-1:0] tap_out
);

   logic signed [fpd_pkg::SAMPLE_W-1:0] tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else if (shift) begin
         tap_ff <= tap_in;
      end
   end

   assign tap_out = tap_ff;

endmodule

>>> hdl/fpd_recip_div.sv
module fpd_recip_div #(
   parameter int WINDOW_TAPS = 10
) (
   input  logic                                                          clock,
   input  logic                                                          load,
   input  logic signed [fpd_pkg::SAMPLE_W+$clog2(WINDOW_TAPS)-1:0]       sum,
   output logic [fpd_pkg::SAMPLE_W:0]                                    quot_mag,
   output logic                                                          quot_neg
);

   localparam int SUM_W  = fpd_pkg::SAMPLE_W + $clog2(WINDOW_TAPS);
   localparam int L      = $clog2(WINDOW_TAPS);
   localparam int M_W    = SUM_W + 1;
   localparam int PROD_W = SUM_W + M_W;
   localparam int Q_W    = fpd_pkg::SAMPLE_W + 1;
   // Rounded-up reciprocal: exact floor division for every magnitude below 2^SUM_W.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << (SUM_W + L)) + 64'(WINDOW_TAPS) - 64'd1) / 64'(WINDOW_TAPS);
   localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

   logic [SUM_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    quot_mag_ff;
   logic              quot_neg_ff;

   // Truncation toward zero: divide the magnitude and restore the sign later.
   assign mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign prod = PROD_W'(mag) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         quot_mag_ff <= prod[PROD_W-1 -: Q_W];
         quot_neg_ff <= sum[SUM_W-1];
      end
   end

   assign quot_mag = quot_mag_ff;
   assign quot_neg = quot_neg_ff;

endmodule

>>> hdl/fpd_peak_stage.sv
module fpd_peak_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [fpd_pkg::SAMPLE_W:0]    quot_mag,
   input  logic                          quot_neg,
   input  logic [fpd_pkg::TS_W-1:0]      timestamp_ms,
   input  fpd_pkg::cfg_type              cfg,
   output fpd_pkg::result_type           result
);

   localparam int W  = fpd_pkg::SAMPLE_W;
   localparam int TW = fpd_pkg::TS_W;
   localparam int IW = fpd_pkg::INTERVAL_W;

   logic signed [W:0]   smooth_wide;
   logic signed [W-1:0] smooth;
   logic signed [W:0]   slope;
   logic                slope_pos;
   logic                slope_neg;
   logic                prev_nonpos;
   logic                prev_nonneg;
   logic                arm_now;
   logic                candidate;
   logic [TW-1:0]       elapsed;
   logic                accept;

   logic signed [W-1:0] prev_smoothed_ff, prev_smoothed_in;
   logic signed [W:0]   prev_slope_ff, prev_slope_in;
   logic                armed_ff, armed_in;
   logic [TW-1:0]       last_peak_ff, last_peak_in;
   logic                seen_peak_ff, seen_peak_in;
   fpd_pkg::result_type result_ff, result_in;

   always_comb begin
      smooth_wide = quot_neg ? -$signed(quot_mag) : $signed(quot_mag);
      smooth      = smooth_wide[W-1:0];
      slope       = $signed({smooth[W-1], smooth}) -
                    $signed({prev_smoothed_ff[W-1], prev_smoothed_ff});
      slope_pos   = !slope[W] && (slope != '0);
      slope_neg   = slope[W];
      prev_nonpos = prev_slope_ff[W] || (prev_slope_ff == '0);
      prev_nonneg = !prev_slope_ff[W];
      arm_now     = (smooth > cfg.peak_threshold) && slope_pos && prev_nonpos;
      // Arming needs a rising slope and a candidate a falling one, so they never coincide.
      candidate   = armed_ff && slope_neg && prev_nonneg;
      elapsed     = timestamp_ms - last_peak_ff;
      accept      = candidate && (elapsed > TW'(cfg.min_peak_spacing_ms));

      prev_smoothed_in = smooth;
      prev_slope_in    = slope;
      armed_in         = candidate ? 1'b0 : (armed_ff || arm_now);
      last_peak_in     = accept ? timestamp_ms : last_peak_ff;
      seen_peak_in     = seen_peak_ff || accept;

      result_in.smoothed       = smooth;
      result_in.peak           = accept;
      result_in.interval_ms    = '0;
      result_in.interval_valid = 1'b0;
      if (accept && seen_peak_ff) begin
         result_in.interval_ms    = (elapsed[TW-1:IW] != '0) ? '1 : elapsed[IW-1:0];
         result_in.interval_valid = (elapsed > TW'(cfg.interval_low_ms)) &&
                                    (elapsed < TW'(cfg.interval_high_ms));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_smoothed_ff <= '0;
         prev_slope_ff    <= '0;
         armed_ff         <= 1'b0;
         last_peak_ff     <= '0;
         seen_peak_ff     <= 1'b0;
      end else if (load) begin
         prev_smoothed_ff <= prev_smoothed_in;
         prev_slope_ff    <= prev_slope_in;
         armed_ff         <= armed_in;
         last_peak_ff     <= last_peak_in;
         seen_peak_ff     <= seen_peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> hdl/filtered_peak_detector_rr.sv
// A request passes the running sum register, the reciprocal multiplier register and
// the detector stage register, which holds the response. Throughput: one request per
// cycle while responses are not stalled; the window is a shift line of tap cells.
// Stalled responses are held in the output register while empty stages keep filling.
// Reset (synchronous) clears the window, the sum, the detector state and the pipeline,
// and loads the configuration registers with their default values.
module filtered_peak_detector_rr #(
   parameter int WINDOW_TAPS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fpd_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic [fpd_pkg::TS_W-1:0]               req_timestamp_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fpd_pkg::SAMPLE_W-1:0]    rsp_smoothed,
   output logic                                   rsp_peak,
   output logic [fpd_pkg::INTERVAL_W-1:0]         rsp_interval_ms,
   output logic                                   rsp_interval_valid,
   input  logic                                   csr_write_enable,
   input  logic [fpd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fpd_pkg::CFG_W-1:0]              csr_write_data
);

   localparam int SUM_W = fpd_pkg::SAMPLE_W + $clog2(WINDOW_TAPS);
   localparam int W     = fpd_pkg::SAMPLE_W;
   localparam int TW    = fpd_pkg::TS_W;

   logic signed [W-1:0] tap_q [WINDOW_TAPS];
   logic signed [SUM_W-1:0] window_sum_ff, window_sum_in;

   logic req_accept;
   logic adv_out, adv2, adv1;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [TW-1:0] s1_ts_ff, s2_ts_ff;
   logic [W:0] quot_mag;
   logic quot_neg;

   fpd_pkg::cfg_type    cfg_ff;
   fpd_pkg::result_type result;

   // Each stage moves on when it is empty or the stage after it moves.
   assign adv_out    = !rsp_valid_ff || rsp_ready;
   assign adv2       = !s2_valid_ff || adv_out;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_ready  = adv1;
   assign req_accept = req_valid && req_ready;

   for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_tap
      if (i == 0) begin : g_head
         fpd_tap_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (req_accept),
            .tap_in  (req_sample),
            .tap_out (tap_q[i])
         );
      end else begin : g_body
         fpd_tap_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (req_accept),
            .tap_in  (tap_q[i-1]),
            .tap_out (tap_q[i])
         );
      end
   end

   // The last cell holds the sample that leaves the window.
   assign window_sum_in = window_sum_ff - SUM_W'(tap_q[WINDOW_TAPS-1]) + SUM_W'(req_sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff <= '0;
      end else if (req_accept) begin
         window_sum_ff <= window_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv_out) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ts_ff <= req_timestamp_ms;
      end
      if (adv2 && s1_valid_ff) begin
         s2_ts_ff <= s1_ts_ff;
      end
   end

   // The window sum register doubles as the first pipeline stage.
   fpd_recip_div #(
      .WINDOW_TAPS (WINDOW_TAPS)
   ) u_div (
      .clock    (clock),
      .load     (adv2 && s1_valid_ff),
      .sum      (window_sum_ff),
      .quot_mag (quot_mag),
      .quot_neg (quot_neg)
   );

   fpd_peak_stage u_peak (
      .clock        (clock),
      .reset        (reset),
      .load         (adv_out && s2_valid_ff),
      .quot_mag     (quot_mag),
      .quot_neg     (quot_neg),
      .timestamp_ms (s2_ts_ff),
      .cfg          (cfg_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_threshold      <= fpd_pkg::RST_PEAK_THRESHOLD;
         cfg_ff.min_peak_spacing_ms <= fpd_pkg::RST_MIN_PEAK_SPACING;
         cfg_ff.interval_low_ms     <= fpd_pkg::RST_INTERVAL_LOW;
         cfg_ff.interval_high_ms    <= fpd_pkg::RST_INTERVAL_HIGH;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fpd_pkg::CSR_PEAK_THRESHOLD: begin
               cfg_ff.peak_threshold <= $signed(csr_write_data);
            end
            fpd_pkg::CSR_MIN_PEAK_SPACING: begin
               cfg_ff.min_peak_spacing_ms <= csr_write_data;
            end
            fpd_pkg::CSR_INTERVAL_LOW: begin
               cfg_ff.interval_low_ms <= csr_write_data;
            end
            fpd_pkg::CSR_INTERVAL_HIGH: begin
               cfg_ff.interval_high_ms <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed       = result.smoothed;
   assign rsp_peak           = result.peak;
   assign rsp_interval_ms    = result.interval_ms;
   assign rsp_interval_valid = result.interval_valid;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not enter the first stage");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv_out) |=> s2_valid_ff)
      else $error("request lost from the multiplier stage while stalled");

   a_no_interval_without_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_peak) |-> (rsp_interval_ms == '0) && !rsp_interval_valid)
      else $error("interval reported on a response without a peak");

   a_valid_interval_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_interval_valid) |-> rsp_peak && (rsp_interval_ms != '0))
      else $error("valid interval flagged without a peak interval");

endmodule
